// ===== sv/tjc_pkg.sv =====
package tjc_pkg;

    // Field widths of the stream and register interfaces.
    localparam int TS_W       = 32;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 63;
    localparam int SRATE_W    = 18;
    localparam int FRATE_W    = 8;
    localparam int STEP_W     = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 96;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default correction parameters.
    localparam int MAX_JITTER_DEF   = 500;
    localparam int DEFAULT_STEP_DEF = 10;

    // Audio rescaling converts samples to milliseconds.
    localparam int MS_PER_S = 1000;

    // Divider sizing: |delta| * 1000 stays below 2^41.
    localparam int DIV_DVD_W = 41;
    localparam int DIV_DVS_W = SRATE_W;

    // Register index, taken from paddr[2].
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_FRAME_RATE  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER = 2'd0,
        KIND_AUDIO = 2'd1,
        KIND_VIDEO = 2'd2
    } kind_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/timestamp_jitter_corrector_core.sv =====
// Timestamp jitter corrector.
//
// Each input item on the s_ channel is one media message: the raw 32-bit
// millisecond timestamp in s_tdata and the message kind (other, audio,
// video) in s_tuser. Each item produces exactly one result item on the m_
// channel carrying the monotonic corrected time, its low 32 bits as the
// rewritten timestamp, and a flag in m_tuser that is set when the raw
// delta was out of range and had to be replaced.
// The APB port holds the audio sample rate (address 0) and the video frame
// rate (address 4); write them only while no message is in flight.
// When the delta is in range, an item passes the prepare and accumulate
// states, and the accumulate state fills the output register. Rescaling
// runs the shared restoring divider between those two states, one quotient
// bit per cycle. The block takes one item at a time.
// Reset (synchronous, active low) clears both rate registers, the previous
// raw timestamp and the corrected time, and empties the output register.
// A finished result waits in the output register; the next item is still
// accepted while it waits, and only the final accumulate step holds until
// the receiver has taken the previous result.
module timestamp_jitter_corrector_core #(
    parameter int MAX_JITTER   = tjc_pkg::MAX_JITTER_DEF,
    parameter int DEFAULT_STEP = tjc_pkg::DEFAULT_STEP_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tjc_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] timestamp
    input  logic [tjc_pkg::KIND_W-1:0]      s_tuser,  // [1:0] kind
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tjc_pkg::M_TDATA_W-1:0]   m_tdata,  // [62:0] adjusted_time,
                                                      // [94:63] out_timestamp,
                                                      // [95] zero
    output logic                            m_tuser,  // [0] jitter_seen
    // Configuration.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tjc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tjc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tjc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import tjc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_ACC  = 4'b1000
    } state_t;

    state_t               state_reg;
    logic [SRATE_W-1:0]   srate_reg;
    logic [FRATE_W-1:0]   frate_reg;
    logic [TS_W-1:0]      prev_raw_reg;
    logic [TIME_W-1:0]    running_reg;
    logic [TIME_W-1:0]    running_next;
    logic [TS_W-1:0]      diff_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic                 neg_reg;
    logic                 jitter_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 m_valid_reg;
    logic [TIME_W-1:0]    m_time_reg;
    logic                 m_jitter_reg;

    logic                 in_accept;
    logic                 cfg_write;
    logic                 out_free;
    logic [TS_W-1:0]      mag;
    logic                 in_range;
    logic [TIME_W:0]      sum;
    logic [DIV_DVD_W-1:0] dvd;
    logic [DIV_DVS_W-1:0] dvs;
    logic [DIV_DVD_W-1:0] quotient;
    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;

    // Configuration registers. The register index is address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srate_reg <= '0;
            frate_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SAMPLE_RATE) begin
                srate_reg <= pwdata[SRATE_W-1:0];
            end else begin
                frate_reg <= pwdata[FRATE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SAMPLE_RATE) begin
            prdata = APB_DATA_W'(srate_reg);
        end else begin
            prdata = APB_DATA_W'(frate_reg);
        end
    end

    // The sequencer takes one item at a time.
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Magnitude of the signed wrapping delta, and the plain range check.
    assign mag      = diff_reg[TS_W-1] ? (~diff_reg + TS_W'(1)) : diff_reg;
    assign in_range = !diff_reg[TS_W-1] && (diff_reg <= TS_W'(MAX_JITTER));

    // Audio divides |delta| * 1000 by the sample rate, video |delta| by the
    // frame rate. The sign of the delta is checked against the quotient afterwards.
    always_comb begin
        div_ctrl.start = 1'b0;
        dvd            = DIV_DVD_W'(mag);
        dvs            = DIV_DVS_W'(frate_reg);
        if (kind_reg == KIND_AUDIO) begin
            dvd = DIV_DVD_W'(mag) * DIV_DVD_W'(MS_PER_S);
            dvs = srate_reg;
        end
        if (state_reg == S_PREP && !in_range) begin
            if (kind_reg == KIND_AUDIO && srate_reg != '0) begin
                div_ctrl.start = 1'b1;
            end else if (kind_reg == KIND_VIDEO && frate_reg != '0) begin
                div_ctrl.start = 1'b1;
            end
        end
    end

    tjc_div #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (dvd),
        .divisor  (dvs),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Saturating accumulate of the corrected time.
    assign sum          = {1'b0, running_reg} + (TIME_W + 1)'(step_reg);
    assign running_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prev_raw_reg <= '0;
            running_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // A new result fills the output register; otherwise it empties
            // once the receiver takes it.
            if (state_reg == S_ACC && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        prev_raw_reg <= s_tdata[TS_W-1:0];
                        state_reg    <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (div_ctrl.start) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_ACC;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (out_free) begin
                        running_reg <= running_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            diff_reg <= s_tdata[TS_W-1:0] - prev_raw_reg;
            kind_reg <= s_tuser;
        end
        if (state_reg == S_PREP) begin
            neg_reg    <= diff_reg[TS_W-1];
            jitter_reg <= !in_range;
            if (in_range) begin
                step_reg <= diff_reg[STEP_W-1:0];
            end else begin
                step_reg <= STEP_W'(DEFAULT_STEP);
            end
        end
        // A negative nonzero quotient or one above the limit falls back to
        // the default step; a quotient truncated to zero is a zero step.
        if (state_reg == S_DIV && div_stat.done) begin
            if ((neg_reg && quotient != '0) ||
                (quotient > DIV_DVD_W'(MAX_JITTER))) begin
                step_reg <= STEP_W'(DEFAULT_STEP);
            end else begin
                step_reg <= quotient[STEP_W-1:0];
            end
        end
        if (state_reg == S_ACC && out_free) begin
            m_time_reg   <= running_next;
            m_jitter_reg <= jitter_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_time_reg[TS_W-1:0], m_time_reg};
    assign m_tuser  = m_jitter_reg;

    // The block never takes two items in back-to-back cycles.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // The corrected time never moves backward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> running_reg >= $past(running_reg))
        else $error("corrected time decreased");

    // The step that is accumulated is in range or is the default step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ACC |->
            (step_reg <= STEP_W'(MAX_JITTER)) || (step_reg == STEP_W'(DEFAULT_STEP)))
        else $error("accumulated step out of range");

    // The divider is only started while it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

// ===== sv/tjc_div.sv =====
module tjc_div #(
    parameter int DVD_W = tjc_pkg::DIV_DVD_W,
    parameter int DVS_W = tjc_pkg::DIV_DVS_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tjc_pkg::div_ctrl_t ctrl,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output tjc_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]  quotient
);
    import tjc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;
    logic             borrow;

    // One quotient bit per cycle, restoring form.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow  = trial[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ~borrow};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== tb/timestamp_jitter_corrector_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the timestamp jitter corrector.
//
// Messages go in on the s_ stream and corrected times come out on the m_
// stream, one result item per message. A predictor in this module keeps
// its own copy of the previous raw timestamp, the running corrected time
// and both rate registers. It computes the expected result at the clock
// edge that accepts each message, and a checker pops those expectations
// in order as results are accepted.
module timestamp_jitter_corrector_core_tb;

    localparam int MAX_JITTER   = tjc_pkg::MAX_JITTER_DEF;
    localparam int DEFAULT_STEP = tjc_pkg::DEFAULT_STEP_DEF;
    localparam int TS_W         = tjc_pkg::TS_W;
    localparam int TIME_W       = tjc_pkg::TIME_W;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // The kind field is two bits wide, but only three codes are defined.
    // The fourth code must behave like a message of the other kind.
    localparam logic [tjc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Register byte addresses. The register index sits in paddr[2].
    localparam logic [tjc_pkg::APB_ADDR_W-1:0] ADDR_SAMPLE_RATE =
        {tjc_pkg::REG_SAMPLE_RATE, 2'b00};
    localparam logic [tjc_pkg::APB_ADDR_W-1:0] ADDR_FRAME_RATE =
        {tjc_pkg::REG_FRAME_RATE, 2'b00};

    // The settle wait outlasts a rescaled item, so the block is idle again after its last result.
    localparam int          SETTLE_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          IDLE_PCT      = 34;

    typedef struct packed {
        logic [TS_W-1:0]           stamp;
        logic [tjc_pkg::KIND_W-1:0] kind;
    } message_t;

    typedef struct packed {
        logic [TIME_W-1:0] corrected;
        logic [TS_W-1:0]   stamp;
        logic              jitter;
    } time_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [tjc_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
    logic [tjc_pkg::KIND_W-1:0]       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tjc_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             m_tuser;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [tjc_pkg::APB_ADDR_W-1:0]   paddr    = '0;
    logic [tjc_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [tjc_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    // Predictor state, mirroring the block after each accepted message.
    logic [TS_W-1:0]              prev_raw_ts  = '0;
    logic [TIME_W-1:0]            corrected_now = '0;
    logic [tjc_pkg::SRATE_W-1:0]  srate_q      = '0;
    logic [tjc_pkg::FRATE_W-1:0]  frate_q      = '0;

    // Results still owed by the block, oldest first.
    time_result_t pending_times[$];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Idle controls. The sender inserts gaps and the receiver stalls when
    // these are set. rx_hold_left forces a long receiver hold-off.
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold_left = 0;

    timestamp_jitter_corrector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Advances the predictor by one message and returns the result the
    // block must produce for it.
    function automatic time_result_t advance_predictor(
        input logic [TS_W-1:0]            stamp,
        input logic [tjc_pkg::KIND_W-1:0] kind
    );
        logic [TS_W-1:0]   raw_diff;
        longint            delta;
        logic [TIME_W-1:0] step;
        time_result_t      res;
        // The wrapping difference is read as a signed 32-bit value.
        raw_diff   = stamp - prev_raw_ts;
        delta      = longint'($signed(raw_diff));
        res.jitter = 1'b0;
        if (delta < 0 || delta > MAX_JITTER) begin
            res.jitter = 1'b1;
            // Both divisions are signed and truncate toward zero, so a
            // slightly negative delta can rescale to a step of zero.
            if (kind == tjc_pkg::KIND_AUDIO && srate_q != '0) begin
                delta = (delta * tjc_pkg::MS_PER_S) / longint'(srate_q);
            end else if (kind == tjc_pkg::KIND_VIDEO && frate_q != '0) begin
                delta = delta / longint'(frate_q);
            end else begin
                delta = DEFAULT_STEP;
            end
            if (delta < 0 || delta > MAX_JITTER) begin
                delta = DEFAULT_STEP;
            end
        end
        step = delta[TIME_W-1:0];
        // The corrected time never wraps; it sticks at its maximum.
        if (corrected_now > TIME_MAX - step) begin
            corrected_now = TIME_MAX;
        end else begin
            corrected_now = corrected_now + step;
        end
        prev_raw_ts   = stamp;
        res.corrected = corrected_now;
        res.stamp     = corrected_now[TS_W-1:0];
        return res;
    endfunction

    // Draws one random message. Most deltas are in range or just beyond
    // what the current rates can rescale, so every branch of the
    // correction is reached often. The rest are wild jumps and fully
    // random timestamps.
    function automatic message_t draw_message();
        message_t m;
        int       pick;
        int       upper;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            m.kind = tjc_pkg::KIND_AUDIO;
        end else if (pick < 70) begin
            m.kind = tjc_pkg::KIND_VIDEO;
        end else if (pick < 90) begin
            m.kind = tjc_pkg::KIND_OTHER;
        end else begin
            m.kind = KIND_UNUSED;
        end
        // Largest delta that still rescales into range, plus a little.
        if (m.kind == tjc_pkg::KIND_AUDIO) begin
            upper = MAX_JITTER + 1 + int'(srate_q) / 2;
        end else if (m.kind == tjc_pkg::KIND_VIDEO) begin
            upper = MAX_JITTER + 1 + MAX_JITTER * int'(frate_q);
        end else begin
            upper = 5000;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            m.stamp = prev_raw_ts + $urandom_range(0, MAX_JITTER);
        end else if (pick < 56) begin
            m.stamp = prev_raw_ts + MAX_JITTER + $urandom_range(0, 1);
        end else if (pick < 74) begin
            m.stamp = prev_raw_ts + $urandom_range(MAX_JITTER + 1, upper);
        end else if (pick < 84) begin
            // Short steps backward often truncate to a zero step.
            m.stamp = prev_raw_ts -
                      $urandom_range(1, $urandom_range(0, 1) ? 300 : upper);
        end else if (pick < 92) begin
            m.stamp = prev_raw_ts + $urandom_range(MAX_JITTER + 1, 32'h7FFF_FFFF);
        end else begin
            m.stamp = $urandom();
        end
        return m;
    endfunction

    // Offers one item on the input stream and records its expected result
    // at the edge that accepts it. The valid stays high after acceptance;
    // the next call or settle_results decides what it does next.
    task automatic send_message(input message_t m);
        @(negedge aclk);
        while (tx_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m.stamp;
        s_tuser  <= m.kind;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_times = {pending_times, advance_predictor(m.stamp, m.kind)};
    endtask

    // Stops offering items, waits for every owed result, then lets the
    // block go quiet.
    task automatic settle_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_times.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register access: a setup phase, then an access phase that ends
    // at the edge with pready high. Writes update the predictor's copy of
    // the register; reads are checked against it.
    task automatic apb_access(
        input logic                              wr,
        input logic [tjc_pkg::APB_ADDR_W-1:0]    addr,
        input logic [tjc_pkg::APB_DATA_W-1:0]    wdata
    );
        logic [tjc_pkg::APB_DATA_W-1:0] want;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        if (wr) begin
            if (addr == ADDR_SAMPLE_RATE) begin
                srate_q = wdata[tjc_pkg::SRATE_W-1:0];
            end else begin
                frate_q = wdata[tjc_pkg::FRATE_W-1:0];
            end
        end else begin
            want = (addr == ADDR_SAMPLE_RATE) ? tjc_pkg::APB_DATA_W'(srate_q)
                                              : tjc_pkg::APB_DATA_W'(frate_q);
            if (prdata !== want) begin
                $display("%0t: register %0d read expected %h, got %h",
                         $time, addr, want, prdata);
                mismatch_count++;
            end
        end
    endtask

    // Loads both rate registers while the block is idle and reads them
    // back. The unused upper bits of each write carry random junk that
    // the block must drop.
    task automatic set_rates(input int srate, input int frate);
        logic [tjc_pkg::APB_DATA_W-1:0] sr_word;
        logic [tjc_pkg::APB_DATA_W-1:0] fr_word;
        settle_results();
        sr_word = $urandom();
        fr_word = $urandom();
        sr_word[tjc_pkg::SRATE_W-1:0] = srate[tjc_pkg::SRATE_W-1:0];
        fr_word[tjc_pkg::FRATE_W-1:0] = frate[tjc_pkg::FRATE_W-1:0];
        apb_access(1'b1, ADDR_SAMPLE_RATE, sr_word);
        apb_access(1'b1, ADDR_FRAME_RATE, fr_word);
        apb_access(1'b0, ADDR_SAMPLE_RATE, '0);
        apb_access(1'b0, ADDR_FRAME_RATE, '0);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Both rates are still unknown after reset, so every jitter delta,
    // whatever its kind, must fall back to the default step. The first
    // message measures its delta from a previous timestamp of zero.
    task automatic test_reset_defaults();
        send_message('{32'd0, tjc_pkg::KIND_OTHER});
        send_message('{32'd500, tjc_pkg::KIND_AUDIO});
        send_message('{32'd1001, tjc_pkg::KIND_VIDEO});
        send_message('{32'd900, tjc_pkg::KIND_AUDIO});
        send_message('{32'hFFFF_FFFF, tjc_pkg::KIND_OTHER});
        send_message('{32'h0000_0100, KIND_UNUSED});
        send_message('{32'h0000_1000, KIND_UNUSED});
    endtask

    // Hand-picked deltas around the rescaling limits at 48 kHz and 30 fps.
    task automatic test_rescale_cases();
        logic [TS_W-1:0] t;
        set_rates(48000, 30);
        t = 32'h0000_1000;
        t = t + 1000;          send_message('{t, tjc_pkg::KIND_AUDIO});
        t = t - 1;             send_message('{t, tjc_pkg::KIND_AUDIO});
        t = t + 15000;         send_message('{t, tjc_pkg::KIND_VIDEO});
        t = t + 15030;         send_message('{t, tjc_pkg::KIND_VIDEO});
        t = t - 29;            send_message('{t, tjc_pkg::KIND_VIDEO});
        t = t + 30000;         send_message('{t, tjc_pkg::KIND_AUDIO});
        t = t + 32'h7FFF_FFFF; send_message('{t, tjc_pkg::KIND_AUDIO});
        t = t + 32'h8000_0000; send_message('{t, tjc_pkg::KIND_VIDEO});
        t = t + 24000;         send_message('{t, tjc_pkg::KIND_OTHER});
        send_message('{t, tjc_pkg::KIND_VIDEO});
        send_message('{32'hFFFF_FFFF, tjc_pkg::KIND_AUDIO});
        send_message('{32'h0000_0000, tjc_pkg::KIND_VIDEO});
    endtask

    task automatic test_random_traffic(input int count, input int srate, input int frate);
        set_rates(srate, frate);
        repeat (count) send_message(draw_message());
    endtask

    // Items offered without gaps, with the receiver always ready.
    task automatic test_full_rate_stream();
        set_rates(48000, 25);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (250) send_message(draw_message());
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // The receiver holds off long enough for the block to fill and push
    // back on the sender. Later the sender pauses until the block has
    // returned everything it owes, then carries on.
    task automatic test_backpressure();
        set_rates(44100, 30);
        @(posedge aclk);
        rx_hold_left = 400;
        repeat (40) send_message(draw_message());
        settle_results();
        repeat (60) send_message(draw_message());
    endtask

    // The receiver side: random stalls, or a forced hold-off while
    // rx_hold_left counts down.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= !(rx_stalls_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Every accepted result is compared field by field with the oldest
    // expectation.
    always @(posedge aclk) begin : check_results
        time_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_times.size() == 0) begin
                $display("%0t: result with none expected, m_tdata=%h m_tuser=%b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_times.pop_front();
                if (m_tdata[TIME_W-1:0] !== want.corrected) begin
                    $display("%0t: adjusted time expected %h, got %h",
                             $time, want.corrected, m_tdata[TIME_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[TIME_W+TS_W-1:TIME_W] !== want.stamp) begin
                    $display("%0t: out_timestamp expected %h, got %h",
                             $time, want.stamp, m_tdata[TIME_W+TS_W-1:TIME_W]);
                    mismatch_count++;
                end
                if (m_tuser !== want.jitter) begin
                    $display("%0t: jitter_seen expected %b, got %b",
                             $time, want.jitter, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset once, then run the directed tests, the random phases over
    // several rate settings (including both extremes), the pressure
    // tests, and finally drain and report.
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_rescale_cases();
        test_random_traffic(200, 0, 0);
        test_random_traffic(300, 44100, 30);
        test_random_traffic(250, 262143, 255);
        test_random_traffic(200, 1, 1);
        test_random_traffic(480, $urandom_range(0, 262143), $urandom_range(0, 255));
        test_full_rate_stream();
        test_backpressure();
        settle_results();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== timestamp_jitter_corrector_core.f =====
sv/tjc_pkg.sv
sv/tjc_div.sv
sv/timestamp_jitter_corrector_core.sv
tb/timestamp_jitter_corrector_core_tb.sv
